// ===== hdl/indexed_deque_assert.svh =====
// Assertion macros shared by the indexed deque RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef INDEXED_DEQUE_ASSERT_SVH
`define INDEXED_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_deque: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_deque: next-cycle check failed");

`endif

// ===== hdl/idq_pkg.sv =====
// Shared types and constants of the indexed deque.
// Depends on nothing; used by idq_ctrl, idq_datapath and indexed_deque.
package idq_pkg;

    localparam int OPCODE_W = 4;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 11;

    // Operation codes; codes nine to fifteen are unused.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_GET        = 4'd4,
        OP_SET        = 4'd5,
        OP_CLEAR      = 4'd6,
        OP_PEEK_FRONT = 4'd7,
        OP_PEEK_BACK  = 4'd8
    } op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } cmd_item_t;

    typedef struct packed {
        logic                     success;
        logic signed [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } res_item_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_free;
    } dp_status_t;

endpackage

// ===== hdl/idq_ctrl.sv =====
// Controller of the indexed deque: sequences accept and execute steps.
// Depends on idq_pkg and indexed_deque_assert.svh.
`include "indexed_deque_assert.svh"

module idq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  idq_pkg::dp_status_t  status,
    output idq_pkg::ctrl_cmd_t   ctl
);

    idq_pkg::state_t state_reg;
    idq_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: an item is taken in idle, then executed once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = idq_pkg::ST_EXEC;
                end
            end
            idq_pkg::ST_EXEC:
            begin
                if (status.res_free)
                begin
                    state_next = idq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = idq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        cmd_stall  = 1'b1;
        ctl.accept = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            idq_pkg::ST_IDLE:
            begin
                cmd_stall  = 1'b0;
                ctl.accept = cmd_valid;
            end
            idq_pkg::ST_EXEC:
            begin
                ctl.exec = status.res_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // An executed item always returns the controller to idle.
    `IDQ_ASSERT_NXT(a_exec_to_idle, clk, rst_n, ctl.exec, state_reg == idq_pkg::ST_IDLE)

endmodule

// ===== hdl/idq_datapath.sv =====
// Datapath of the indexed deque: item register, ring store, pointers, result register.
// Depends on idq_pkg and indexed_deque_assert.svh.
`include "indexed_deque_assert.svh"

module idq_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  idq_pkg::ctrl_cmd_t   ctl,
    output idq_pkg::dp_status_t  status,
    input  idq_pkg::cmd_item_t   cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output idq_pkg::res_item_t   res
);

    localparam int AddrW = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int OffW  = (CntW > idq_pkg::POS_W) ? CntW : idq_pkg::POS_W;
    localparam int SumW  = OffW + 1;
    localparam int OccW  = idq_pkg::OCC_W;

    // Slot that lies a given distance past the front, modulo the capacity.
    function automatic logic [AddrW-1:0] slot_at(input logic [AddrW-1:0] base,
                                                input logic [OffW-1:0] off);
        logic [SumW-1:0] sum;
        sum = SumW'(base) + SumW'(off);
        if (sum >= SumW'(CAPACITY))
        begin
            sum = sum - SumW'(CAPACITY);
        end
        return sum[AddrW-1:0];
    endfunction

    logic [idq_pkg::DATA_W-1:0] store_mem [CAPACITY];

    idq_pkg::cmd_item_t         item_reg;
    logic [idq_pkg::DATA_W-1:0] rd_data_reg;
    logic [AddrW-1:0]           front_reg;
    logic [AddrW-1:0]           front_next;
    logic [CntW-1:0]            count_reg;
    logic [CntW-1:0]            count_next;
    idq_pkg::res_item_t         res_reg;
    idq_pkg::res_item_t         res_next;
    logic                       res_valid_reg;

    logic [AddrW-1:0]           rd_addr;
    logic [AddrW-1:0]           wr_addr;
    logic                       wr_en;
    logic                       ok;
    logic                       has_entry;
    logic                       not_full;
    logic                       pos_ok;

    // Read address for the incoming item, from the pointers as they stand.
    always_comb
    begin
        unique case (idq_pkg::op_t'(cmd.opcode))
            idq_pkg::OP_GET:
            begin
                rd_addr = slot_at(front_reg, OffW'(cmd.position));
            end
            idq_pkg::OP_PEEK_BACK:
            begin
                rd_addr = slot_at(front_reg, OffW'(count_reg - CntW'(1)));
            end
            default:
            begin
                rd_addr = front_reg;
            end
        endcase
    end

    // Item capture and store read on accept.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            item_reg    <= cmd;
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Store write during execution.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= item_reg.data_in;
        end
    end

    // Operation decode and pointer update for the held item.
    always_comb
    begin
        has_entry  = (count_reg != '0);
        not_full   = (count_reg != CntW'(CAPACITY));
        pos_ok     = (OffW'(item_reg.position) < OffW'(count_reg));
        ok         = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = slot_at(front_reg, OffW'(item_reg.position));
        front_next = front_reg;
        count_next = count_reg;
        res_next.data_out = '0;
        unique case (idq_pkg::op_t'(item_reg.opcode))
            idq_pkg::OP_PUSH_FRONT:
            begin
                if (not_full)
                begin
                    ok         = 1'b1;
                    front_next = (front_reg == '0) ? AddrW'(CAPACITY - 1)
                                                   : front_reg - AddrW'(1);
                    wr_addr    = front_next;
                    wr_en      = 1'b1;
                    count_next = count_reg + CntW'(1);
                end
            end
            idq_pkg::OP_PUSH_BACK:
            begin
                if (not_full)
                begin
                    ok         = 1'b1;
                    wr_addr    = slot_at(front_reg, OffW'(count_reg));
                    wr_en      = 1'b1;
                    count_next = count_reg + CntW'(1);
                end
            end
            idq_pkg::OP_POP_FRONT:
            begin
                if (has_entry)
                begin
                    ok         = 1'b1;
                    front_next = slot_at(front_reg, OffW'(1));
                    count_next = count_reg - CntW'(1);
                end
            end
            idq_pkg::OP_POP_BACK:
            begin
                if (has_entry)
                begin
                    ok         = 1'b1;
                    count_next = count_reg - CntW'(1);
                end
            end
            idq_pkg::OP_GET:
            begin
                if (pos_ok)
                begin
                    ok                = 1'b1;
                    res_next.data_out = rd_data_reg;
                end
            end
            idq_pkg::OP_SET:
            begin
                if (pos_ok)
                begin
                    ok    = 1'b1;
                    wr_en = 1'b1;
                end
            end
            idq_pkg::OP_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            idq_pkg::OP_PEEK_FRONT,
            idq_pkg::OP_PEEK_BACK:
            begin
                if (has_entry)
                begin
                    ok                = 1'b1;
                    res_next.data_out = rd_data_reg;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        wr_en              = wr_en & ctl.exec;
        res_next.success   = ok;
        res_next.occupancy = OccW'(count_next);
        res_next.is_empty  = (count_next == '0);
    end

    // Front pointer and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Result register: loaded on execution, emptied when the item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            res_reg <= res_next;
        end
    end

    assign status.res_free = !res_valid_reg || !res_stall;
    assign res_valid       = res_valid_reg;
    assign res             = res_reg;

    // The count never passes the capacity and the front stays inside the ring.
    `IDQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CntW'(CAPACITY))
    `IDQ_ASSERT_IMP(a_front_bound, clk, rst_n, 1'b1, SumW'(front_reg) < SumW'(CAPACITY))
    // A clear that executes leaves the deque empty.
    `IDQ_ASSERT_NXT(a_clear_empties, clk, rst_n,
        ctl.exec && (item_reg.opcode == idq_pkg::OP_CLEAR), count_reg == '0)
    // A failed operation never returns read data.
    `IDQ_ASSERT_IMP(a_fail_zero_data, clk, rst_n,
        res_valid_reg && !res_reg.success, res_reg.data_out == '0)

endmodule

// ===== hdl/indexed_deque.sv =====
// Indexed deque: a bounded double-ended queue of signed 32-bit values in a ring store.
// A result is registered in the execute state after the accept; execution waits while the
// output register holds an untaken result. Items go one at a time, each with a store read
// registered on accept. The next item is taken while an earlier result still waits in the
// output register. Reset clears the front pointer, the count and the result valid flag; the
// store is not cleared and needs no clearing pass, since only written entries are ever read.
module indexed_deque #(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  idq_pkg::cmd_item_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output idq_pkg::res_item_t  res
);

    idq_pkg::ctrl_cmd_t  ctl;
    idq_pkg::dp_status_t status;

    // Sequencer.
    idq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctl       (ctl)
    );

    // Store, pointers and result register.
    idq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
